// ===== sv/vt_pkg.sv =====
package vt_pkg;

    // Parameter slots counted per sequence (only the first two are stored)
    localparam int MAX_PARAMS_DEF = 9;

    localparam int DATA_W  = 8;
    localparam int ARG_W   = 16;
    localparam int ACT_W   = 5;
    // action + two args + char + insert_before + three modes, padded to bytes
    localparam int OUT_W   = ACT_W + 2 * ARG_W + DATA_W + 4;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

    localparam logic [ARG_W-1:0] ACC_MAX = 16'hFFFF;

    // Parser phases
    typedef enum logic [2:0] {
        PH_BASIC   = 3'd0,
        PH_ESCAPE  = 3'd1,
        PH_BRACKET = 3'd2,
        PH_NUMBER  = 3'd3,
        PH_DIGIT   = 3'd4,
        PH_ACTION  = 3'd5
    } t_phase;

    // Decoded action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_PENDING     = 5'd0,
        ACT_ADD         = 5'd1,
        ACT_BELL        = 5'd2,
        ACT_LEFT        = 5'd3,
        ACT_DOWN        = 5'd4,
        ACT_UP          = 5'd5,
        ACT_RIGHT       = 5'd6,
        ACT_CR          = 5'd7,
        ACT_POS         = 5'd8,
        ACT_CLR_SCR     = 5'd9,
        ACT_CLR_LINE    = 5'd10,
        ACT_INS_LINES   = 5'd11,
        ACT_DEL_LINES   = 5'd12,
        ACT_DEL_CHARS   = 5'd13,
        ACT_INS_CHARS   = 5'd14,
        ACT_ATTR_RESET  = 5'd15,
        ACT_ATTR_ADD    = 5'd16,
        ACT_ATTR_REMOVE = 5'd17,
        ACT_FG          = 5'd18,
        ACT_BG          = 5'd19,
        ACT_SCROLL      = 5'd20,
        ACT_VIS         = 5'd21,
        ACT_FLASH       = 5'd22,
        ACT_MODE        = 5'd23,
        ACT_UNEXPECTED  = 5'd24
    } t_action;

    // Attribute codes carried in arg_first
    localparam logic [ARG_W-1:0] ATTR_BOLD      = 16'd0;
    localparam logic [ARG_W-1:0] ATTR_BLINK     = 16'd1;
    localparam logic [ARG_W-1:0] ATTR_REVERSE   = 16'd2;
    localparam logic [ARG_W-1:0] ATTR_STANDOUT  = 16'd3;
    localparam logic [ARG_W-1:0] ATTR_UNDERLINE = 16'd4;

    // Control and sequence bytes
    localparam logic [DATA_W-1:0] CH_BEL   = 8'h07;
    localparam logic [DATA_W-1:0] CH_BS    = 8'h08;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [DATA_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [DATA_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [DATA_W-1:0] CH_GT    = 8'h3E;
    localparam logic [DATA_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [DATA_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [DATA_W-1:0] CH_AT    = 8'h40;
    localparam logic [DATA_W-1:0] CH_UA    = 8'h41;
    localparam logic [DATA_W-1:0] CH_UB    = 8'h42;
    localparam logic [DATA_W-1:0] CH_UC    = 8'h43;
    localparam logic [DATA_W-1:0] CH_UD    = 8'h44;
    localparam logic [DATA_W-1:0] CH_UH    = 8'h48;
    localparam logic [DATA_W-1:0] CH_UJ    = 8'h4A;
    localparam logic [DATA_W-1:0] CH_UK    = 8'h4B;
    localparam logic [DATA_W-1:0] CH_UL    = 8'h4C;
    localparam logic [DATA_W-1:0] CH_UM    = 8'h4D;
    localparam logic [DATA_W-1:0] CH_UP    = 8'h50;
    localparam logic [DATA_W-1:0] CH_LG    = 8'h67;
    localparam logic [DATA_W-1:0] CH_LH    = 8'h68;
    localparam logic [DATA_W-1:0] CH_LL    = 8'h6C;
    localparam logic [DATA_W-1:0] CH_LM    = 8'h6D;
    localparam logic [DATA_W-1:0] CH_LR    = 8'h72;
    localparam logic [DATA_W-1:0] CH_D0    = 8'h30;
    localparam logic [DATA_W-1:0] CH_D9    = 8'h39;

    // Mode numbers
    localparam logic [ARG_W-1:0] MODE_KEYPAD = 16'd1;
    localparam logic [ARG_W-1:0] MODE_INSERT = 16'd4;
    localparam logic [ARG_W-1:0] MODE_CURSOR = 16'd25;
    localparam logic [ARG_W-1:0] MODE_VIS    = 16'd34;
    localparam logic [ARG_W-1:0] MODE_PASTE  = 16'd2004;

    // Graphic rendition numbers
    localparam logic [ARG_W-1:0] SGR_BOLD      = 16'd1;
    localparam logic [ARG_W-1:0] SGR_STANDOUT  = 16'd3;
    localparam logic [ARG_W-1:0] SGR_UNDERLINE = 16'd4;
    localparam logic [ARG_W-1:0] SGR_BLINK     = 16'd5;
    localparam logic [ARG_W-1:0] SGR_REVERSE   = 16'd7;
    localparam logic [ARG_W-1:0] SGR_NO_STAND  = 16'd23;
    localparam logic [ARG_W-1:0] SGR_NO_UNDER  = 16'd24;
    localparam logic [ARG_W-1:0] SGR_FG_BASE   = 16'd30;
    localparam logic [ARG_W-1:0] SGR_FG_LAST   = 16'd37;
    localparam logic [ARG_W-1:0] SGR_BG_BASE   = 16'd40;
    localparam logic [ARG_W-1:0] SGR_BG_LAST   = 16'd47;

endpackage

// ===== sv/vt100_output_escape_parser.sv =====
// A word accepted on s_axis is held in the input register, decoded into the result
// register and offered on m_axis from there.
// Throughput: one word per cycle; the parser state loop closes in the decode stage.
// Back-pressure on m_axis stalls the input register and then s_axis_tready.
// Reset (i_rst_n low, synchronous) empties both registers, returns the parser
// to the basic phase and clears parameters and the insert, keypad and paste modes.
module vt100_output_escape_parser #(
    parameter int MAX_PARAMS = vt_pkg::MAX_PARAMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] data_byte
    input  logic [vt_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [4:0] action, [20:5] arg_first, [36:21] arg_second, [44:37] char_out,
    // [45] insert_before, [46] insert_mode_now, [47] keypad_mode_now,
    // [48] paste_mode_now, [55:49] zero
    output logic [vt_pkg::OUT_TW-1:0] m_axis_tdata,
    // sequence_done
    output logic                      m_axis_tlast
);

    localparam int CntW  = $clog2(MAX_PARAMS + 1);
    localparam int AccW  = vt_pkg::ARG_W + 4;
    localparam int ArgW  = vt_pkg::ARG_W;
    localparam int DataW = vt_pkg::DATA_W;

    // Input stage
    logic             r_in_valid;
    logic [DataW-1:0] r_in_data;
    logic             adv;

    // Parser state
    vt_pkg::t_phase   r_phase, n_phase, s_phase;
    logic             r_qp, n_qp;
    logic [ArgW-1:0]  r_acc, n_acc;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [ArgW-1:0]  r_p1, n_p1;
    logic [ArgW-1:0]  r_p2, n_p2;
    logic             r_ins, n_ins;
    logic             r_kp, n_kp;
    logic             r_paste, n_paste;

    // Result register
    logic             r_out_valid;
    vt_pkg::t_action  r_act, n_act;
    logic [ArgW-1:0]  r_a1, n_a1;
    logic [ArgW-1:0]  r_a2, n_a2;
    logic [DataW-1:0] r_ch, n_ch;
    logic             r_ib, n_ib;
    logic             r_done;

    // Decode helpers
    logic [DataW-1:0] b;
    logic             is_digit;
    logic [AccW-1:0]  acc_mul;
    logic             do_act;
    logic             cont;
    logic             unexp;
    logic [ArgW-1:0]  count_arg;
    logic             on_h;

    assign b        = r_in_data;
    assign is_digit = (b >= vt_pkg::CH_D0) && (b <= vt_pkg::CH_D9);
    // acc * 10 + digit as shift-add
    assign acc_mul  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {{(AccW-4){1'b0}}, b[3:0]};

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    // Next phase, prefix, accumulator and parameters
    always_comb begin
        s_phase = r_phase;
        n_qp    = r_qp;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_p1    = r_p1;
        n_p2    = r_p2;
        do_act  = 1'b0;
        cont    = 1'b0;
        case (r_phase)
            vt_pkg::PH_ESCAPE: begin
                if (b == vt_pkg::CH_LBRK) begin
                    s_phase = vt_pkg::PH_BRACKET;
                    cont    = 1'b1;
                end
            end
            vt_pkg::PH_BRACKET, vt_pkg::PH_NUMBER: begin
                if (r_phase == vt_pkg::PH_BRACKET && !r_qp && b == vt_pkg::CH_QUERY) begin
                    n_qp = 1'b1;
                    cont = 1'b1;
                end else if (is_digit) begin
                    n_acc   = {{(ArgW-4){1'b0}}, b[3:0]};
                    s_phase = vt_pkg::PH_DIGIT;
                    cont    = 1'b1;
                end else begin
                    s_phase = vt_pkg::PH_ACTION;
                    do_act  = 1'b1;
                end
            end
            vt_pkg::PH_DIGIT: begin
                if (is_digit) begin
                    n_acc = (acc_mul > AccW'(vt_pkg::ACC_MAX)) ? vt_pkg::ACC_MAX
                                                              : acc_mul[ArgW-1:0];
                    cont  = 1'b1;
                end else begin
                    // count the finished parameter up to the limit, store only the first two
                    if (r_cnt < CntW'(MAX_PARAMS)) begin
                        if (r_cnt == CntW'(0)) begin
                            n_p1 = r_acc;
                        end else if (r_cnt == CntW'(1)) begin
                            n_p2 = r_acc;
                        end
                        n_cnt = r_cnt + CntW'(1);
                    end
                    n_acc = '0;
                    if (b == vt_pkg::CH_SEMI) begin
                        cont = 1'b1;
                    end else begin
                        s_phase = vt_pkg::PH_ACTION;
                        do_act  = 1'b1;
                    end
                end
            end
            vt_pkg::PH_ACTION: begin
                do_act = 1'b1;
            end
            default: begin
                n_qp  = 1'b0;
                n_cnt = '0;
                if (b == vt_pkg::CH_ESC) begin
                    s_phase = vt_pkg::PH_ESCAPE;
                    cont    = 1'b1;
                end
            end
        endcase
        n_phase = cont ? s_phase : vt_pkg::PH_BASIC;
    end

    assign count_arg = (n_cnt == CntW'(0)) ? ArgW'(1) : n_p1;
    assign on_h      = (b == vt_pkg::CH_LH);

    // Action, arguments and mode updates
    always_comb begin
        n_act   = vt_pkg::ACT_PENDING;
        n_a1    = '0;
        n_a2    = '0;
        n_ch    = '0;
        n_ib    = 1'b0;
        n_ins   = r_ins;
        n_kp    = r_kp;
        n_paste = r_paste;
        unexp   = 1'b0;
        if (do_act && n_qp) begin
            // private modes
            if ((b == vt_pkg::CH_LH || b == vt_pkg::CH_LL) && n_cnt == CntW'(1)) begin
                if (n_p1 == vt_pkg::MODE_KEYPAD) begin
                    n_kp  = on_h;
                    n_act = vt_pkg::ACT_MODE;
                end else if (n_p1 == vt_pkg::MODE_CURSOR) begin
                    n_act = vt_pkg::ACT_VIS;
                    n_a1  = ArgW'(on_h);
                end else if (n_p1 == vt_pkg::MODE_PASTE) begin
                    n_paste = on_h;
                    n_act   = vt_pkg::ACT_MODE;
                end else begin
                    unexp = 1'b1;
                end
            end else begin
                unexp = 1'b1;
            end
        end else if (do_act) begin
            case (b)
                vt_pkg::CH_UA: begin n_act = vt_pkg::ACT_UP;    n_a1 = count_arg; end
                vt_pkg::CH_UB: begin n_act = vt_pkg::ACT_DOWN;  n_a1 = count_arg; end
                vt_pkg::CH_UC: begin n_act = vt_pkg::ACT_RIGHT; n_a1 = count_arg; end
                vt_pkg::CH_UD: begin n_act = vt_pkg::ACT_LEFT;  n_a1 = count_arg; end
                vt_pkg::CH_UH: begin
                    if (n_cnt == CntW'(0)) begin
                        n_act = vt_pkg::ACT_POS;
                    end else if (n_cnt == CntW'(2) && n_p1 != '0 && n_p2 != '0) begin
                        n_act = vt_pkg::ACT_POS;
                        n_a1  = n_p1 - ArgW'(1);
                        n_a2  = n_p2 - ArgW'(1);
                    end else begin
                        unexp = 1'b1;
                    end
                end
                vt_pkg::CH_UJ: n_act = vt_pkg::ACT_CLR_SCR;
                vt_pkg::CH_UK: n_act = vt_pkg::ACT_CLR_LINE;
                vt_pkg::CH_UL: begin n_act = vt_pkg::ACT_INS_LINES; n_a1 = count_arg; end
                vt_pkg::CH_UM: begin n_act = vt_pkg::ACT_DEL_LINES; n_a1 = count_arg; end
                vt_pkg::CH_UP: begin n_act = vt_pkg::ACT_DEL_CHARS; n_a1 = count_arg; end
                vt_pkg::CH_AT: begin n_act = vt_pkg::ACT_INS_CHARS; n_a1 = count_arg; end
                vt_pkg::CH_LH, vt_pkg::CH_LL: begin
                    if (n_cnt == CntW'(1) && n_p1 == vt_pkg::MODE_INSERT) begin
                        n_ins = on_h;
                        n_act = vt_pkg::ACT_MODE;
                    end else if (n_cnt == CntW'(1) && n_p1 == vt_pkg::MODE_VIS) begin
                        n_act = vt_pkg::ACT_VIS;
                        n_a1  = on_h ? ArgW'(1) : ArgW'(2);
                    end else begin
                        unexp = 1'b1;
                    end
                end
                vt_pkg::CH_LM: begin
                    if (n_cnt == CntW'(0)) begin
                        n_act = vt_pkg::ACT_ATTR_RESET;
                    end else if (n_cnt != CntW'(1)) begin
                        unexp = 1'b1;
                    end else begin
                        case (n_p1)
                            vt_pkg::SGR_BOLD: begin
                                n_act = vt_pkg::ACT_ATTR_ADD;
                                n_a1  = vt_pkg::ATTR_BOLD;
                            end
                            vt_pkg::SGR_BLINK: begin
                                n_act = vt_pkg::ACT_ATTR_ADD;
                                n_a1  = vt_pkg::ATTR_BLINK;
                            end
                            vt_pkg::SGR_REVERSE: begin
                                n_act = vt_pkg::ACT_ATTR_ADD;
                                n_a1  = vt_pkg::ATTR_REVERSE;
                            end
                            vt_pkg::SGR_STANDOUT: begin
                                n_act = vt_pkg::ACT_ATTR_ADD;
                                n_a1  = vt_pkg::ATTR_STANDOUT;
                            end
                            vt_pkg::SGR_UNDERLINE: begin
                                n_act = vt_pkg::ACT_ATTR_ADD;
                                n_a1  = vt_pkg::ATTR_UNDERLINE;
                            end
                            vt_pkg::SGR_NO_STAND: begin
                                n_act = vt_pkg::ACT_ATTR_REMOVE;
                                n_a1  = vt_pkg::ATTR_STANDOUT;
                            end
                            vt_pkg::SGR_NO_UNDER: begin
                                n_act = vt_pkg::ACT_ATTR_REMOVE;
                                n_a1  = vt_pkg::ATTR_UNDERLINE;
                            end
                            default: begin
                                // colour is the parameter's last digit
                                if (n_p1 inside {[vt_pkg::SGR_FG_BASE:vt_pkg::SGR_FG_LAST]}) begin
                                    n_act = vt_pkg::ACT_FG;
                                    n_a1  = n_p1 - vt_pkg::SGR_FG_BASE;
                                end else if (n_p1 inside
                                             {[vt_pkg::SGR_BG_BASE:vt_pkg::SGR_BG_LAST]}) begin
                                    n_act = vt_pkg::ACT_BG;
                                    n_a1  = n_p1 - vt_pkg::SGR_BG_BASE;
                                end else begin
                                    unexp = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                vt_pkg::CH_LR: begin
                    if (n_cnt == CntW'(2) && n_p1 != '0 && n_p2 != '0) begin
                        n_act = vt_pkg::ACT_SCROLL;
                        n_a1  = n_p1 - ArgW'(1);
                        n_a2  = n_p2 - ArgW'(1);
                    end else begin
                        unexp = 1'b1;
                    end
                end
                default: unexp = 1'b1;
            endcase
        end else if (r_phase == vt_pkg::PH_ESCAPE) begin
            case (b)
                vt_pkg::CH_LBRK: n_act = vt_pkg::ACT_PENDING;
                vt_pkg::CH_EQ: begin n_kp = 1'b1; n_act = vt_pkg::ACT_MODE; end
                vt_pkg::CH_GT: begin n_kp = 1'b0; n_act = vt_pkg::ACT_MODE; end
                vt_pkg::CH_UM: begin n_act = vt_pkg::ACT_UP; n_a1 = ArgW'(1); end
                vt_pkg::CH_LG: n_act = vt_pkg::ACT_FLASH;
                default:       unexp = 1'b1;
            endcase
        end else if (!cont && (r_phase == vt_pkg::PH_BASIC || r_phase > vt_pkg::PH_ACTION)) begin
            case (b)
                vt_pkg::CH_BEL: n_act = vt_pkg::ACT_BELL;
                vt_pkg::CH_BS:  begin n_act = vt_pkg::ACT_LEFT; n_a1 = ArgW'(1); end
                vt_pkg::CH_LF:  begin n_act = vt_pkg::ACT_DOWN; n_a1 = ArgW'(1); end
                vt_pkg::CH_CR:  n_act = vt_pkg::ACT_CR;
                default: begin
                    n_act = vt_pkg::ACT_ADD;
                    n_ch  = b;
                    n_ib  = r_ins;
                end
            endcase
        end
        // an unexpected byte clears every argument
        if (unexp) begin
            n_act = vt_pkg::ACT_UNEXPECTED;
            n_a1  = '0;
            n_a2  = '0;
            n_ch  = '0;
            n_ib  = 1'b0;
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= vt_pkg::PH_BASIC;
            r_qp        <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_p1        <= '0;
            r_p2        <= '0;
            r_ins       <= 1'b0;
            r_kp        <= 1'b0;
            r_paste     <= 1'b0;
        end else begin
            // load the input word
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            // advance the parser and hold the result until taken
            if (adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_qp        <= n_qp;
                r_acc       <= n_acc;
                r_cnt       <= n_cnt;
                r_p1        <= n_p1;
                r_p2        <= n_p2;
                r_ins       <= n_ins;
                r_kp        <= n_kp;
                r_paste     <= n_paste;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
        if (adv) begin
            r_act  <= n_act;
            r_a1   <= n_a1;
            r_a2   <= n_a2;
            r_ch   <= n_ch;
            r_ib   <= n_ib;
            r_done <= !cont;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_done;
    assign m_axis_tdata  = {{(vt_pkg::OUT_TW - vt_pkg::OUT_W){1'b0}},
                            r_paste, r_kp, r_ins, r_ib, r_ch, r_a2, r_a1, r_act};

endmodule

// ===== sv/vt_chk.sv =====
module vt_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [vt_pkg::OUT_TW-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);

    logic [vt_pkg::ACT_W-1:0] act;
    assign act = m_axis_tdata[vt_pkg::ACT_W-1:0];

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Input side stays open while no result word waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with an empty result register");

    // Action code stays within the defined set
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> act <= vt_pkg::ACT_UNEXPECTED)
        else $error("action code out of range");

    // A sequence ends exactly on a non-pending action
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (act != vt_pkg::ACT_PENDING)))
        else $error("sequence end does not match action");

    // Only add_char carries a character or an insert request
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && act != vt_pkg::ACT_ADD |->
            m_axis_tdata[44:37] == '0 && !m_axis_tdata[45])
        else $error("character field set on a non-add action");

endmodule

bind vt100_output_escape_parser vt_chk u_vt_chk (.*);
